### src/tensor_diffusion_stencil_2d_macros.svh
// Assertion helpers used by the RTL.
`ifndef TENSOR_DIFFUSION_STENCIL_2D_MACROS_SVH
`define TENSOR_DIFFUSION_STENCIL_2D_MACROS_SVH

// Same-cycle implication.
`define TDS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/tds_pkg.sv
`default_nettype none
package tds_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int TENSOR_BITS    = 16;
  localparam int STEP_BITS      = 16;
  localparam int STEP_FRAC_BITS = 12;
  localparam int NUM_TAPS       = 9;
  // Twice the weighted sum fits in this many signed bits.
  localparam int SUM_BITS       = 38;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_STEP_SIZE    = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic                           flush;
    logic        [SAMPLE_BITS-1:0]  sample;
    logic signed [TENSOR_BITS-1:0]  dxx;
    logic signed [TENSOR_BITS-1:0]  dxy;
    logic signed [TENSOR_BITS-1:0]  dyy;
  } pixel_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] new_value;
    logic                   end_of_frame;
  } result_t;

endpackage
`default_nettype wire

### src/tensor_diffusion_stencil_2d.sv
// An emitting request passes through the shift, multiply, sum, scale and saturate
//   steps before its result is valid; a request that emits nothing only shifts.
// A new request is taken only in idle, once the last one has finished, including any
//   wait in the finish step while the result output is stalled.
// Output lags input by frame width + 1 positions. Reset clears positions, counters,
//   window and registers to defaults; line-store contents stay undefined.
`default_nettype none
`include "tensor_diffusion_stencil_2d_macros.svh"
module tensor_diffusion_stencil_2d #(
  parameter int MAX_WIDTH        = 1024,
  parameter int TENSOR_FRAC_BITS = 14
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                pixel_valid,
  output logic                               pixel_ready,
  input  tds_pkg::pixel_t                    pixel,
  output logic                               result_valid,
  input  wire                                result_ready,
  output tds_pkg::result_t                   result,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [tds_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire [tds_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import tds_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WB  = $clog2(MAX_WIDTH + 1);
  localparam int CB  = $clog2(MAX_WIDTH + 2);
  localparam int FB  = TENSOR_FRAC_BITS + STEP_FRAC_BITS + 1;
  localparam int MW  = SUM_BITS - 1;
  localparam int PW  = MW + STEP_BITS;
  localparam int QW  = PW - FB;
  localparam int TW  = 3 * TENSOR_BITS;
  localparam int DW  = 2 * SAMPLE_BITS + TW;
  localparam int HB  = 16;
  localparam int WRB = 11;
  localparam logic [SAMPLE_BITS-1:0] SMAX = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_SHIFT, S_MUL, S_SUM, S_SCALE, S_FIN
  } state_t;

  state_t state;

  // Configuration
  logic [WRB-1:0]       frame_width;
  logic [HB-1:0]        frame_height;
  logic [STEP_BITS-1:0] step_size;
  logic [WB-1:0]        w_eff;
  logic [HB-1:0]        h_eff;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = WB'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = WB'(MAX_WIDTH);
    end else begin
      w_eff = WB'(frame_width);
    end
    h_eff = (frame_height == '0) ? HB'(1) : frame_height;
  end

  // Positions and fill count
  logic [AW-1:0] in_column;
  logic [HB-1:0] in_row;
  logic [AW-1:0] out_column;
  logic [HB-1:0] out_row;
  logic [CB-1:0] pending;

  // Line store: above row, centre row, tensor row in one word
  logic [DW-1:0] line_mem [MAX_WIDTH];
  logic [DW-1:0] line_q;

  // Captured request
  logic                   itm_emit;
  logic [SAMPLE_BITS-1:0] itm_sample;
  logic [TW-1:0]          itm_tensor;
  logic                   itm_last;

  logic [SAMPLE_BITS-1:0] win [NUM_TAPS];
  logic [TW-1:0]          tensor_hold;

  // Datapath registers
  logic [SAMPLE_BITS-1:0]  nb [NUM_TAPS];
  logic [TW-1:0]           nb_tensor;
  logic                    nb_eof;
  logic signed [33:0]      p_xy, p_yy, p_xx;
  logic                    neg;
  logic [MW-1:0]           mag;
  logic [PW-1:0]           prod;

  logic accept, cfg_accept, emit_now;
  // Register writes take priority over requests and only land while idle
  assign pixel_ready = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready   = (state == S_IDLE);
  assign accept      = pixel_valid && pixel_ready;
  assign cfg_accept  = cfg_valid && cfg_ready;

  // A flush emits when anything is pending; a pixel emits once the pipe is full
  assign emit_now = pixel.flush ? (pending != '0)
                                : (32'(pending) == 32'(w_eff) + 1);

  // Window shift and neighbor gathering (out-of-frame neighbors take the centre value)
  logic [SAMPLE_BITS-1:0] sh [NUM_TAPS];
  logic [SAMPLE_BITS-1:0] src [NUM_TAPS];
  logic [SAMPLE_BITS-1:0] nb_next [NUM_TAPS];
  logic                   col0;
  logic [1:0]             cc;
  logic [SAMPLE_BITS-1:0] cval;

  always_comb begin
    logic rout, cout;
    logic [2:0] col;
    for (int r = 0; r < 3; r++) begin
      sh[r*3]     = win[r*3+1];
      sh[r*3+1]   = win[r*3+2];
      sh[r*3+2]   = win[r*3+2];
    end
    sh[2] = line_q[SAMPLE_BITS-1:0];
    sh[5] = line_q[2*SAMPLE_BITS-1:SAMPLE_BITS];
    sh[8] = itm_sample;
    col0 = (in_column == '0);
    cc   = col0 ? 2'd2 : 2'd1;
    for (int i = 0; i < NUM_TAPS; i++) begin
      src[i] = col0 ? win[i] : sh[i];
    end
    cval = src[3 + 32'(cc)];
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        rout = (r == 0 && out_row == '0) ||
               (r == 2 && 32'(out_row) + 1 >= 32'(h_eff));
        cout = (k == 0 && out_column == '0) ||
               (k == 2 && (col0 || 32'(out_column) + 1 >= 32'(w_eff)));
        col  = 3'(32'(cc) + k - 1);
        if (col > 3'd2) begin
          col = 3'd2;
        end
        nb_next[r*3+k] = (rout || cout) ? cval : src[r*3 + 32'(col)];
      end
    end
  end

  // Stencil term inputs
  logic signed [17:0] diag_d, vert_d, horz_d;
  always_comb begin
    diag_d = $signed({2'b00, nb[2]}) + $signed({2'b00, nb[6]})
           - $signed({2'b00, nb[0]}) - $signed({2'b00, nb[8]});
    vert_d = $signed({2'b00, nb[1]}) + $signed({2'b00, nb[7]})
           - $signed({1'b0, nb[4], 1'b0});
    horz_d = $signed({2'b00, nb[3]}) + $signed({2'b00, nb[5]})
           - $signed({1'b0, nb[4], 1'b0});
  end

  logic signed [SUM_BITS-1:0] s2;
  assign s2 = SUM_BITS'(p_xy) + (SUM_BITS'(p_yy) <<< 1) + (SUM_BITS'(p_xx) <<< 1);

  // Final truncation and saturation
  logic [QW-1:0]          q;
  logic                   frac;
  logic                   big;
  logic [SAMPLE_BITS:0]   up_sum;
  logic [SAMPLE_BITS-1:0] res_val;
  always_comb begin
    q      = prod[PW-1:FB];
    frac   = (prod[FB-1:0] != '0);
    big    = 64'(q) > 64'(SMAX);
    up_sum = {1'b0, nb[4]} + (SAMPLE_BITS+1)'(q[SAMPLE_BITS-1:0]);
    if (!neg) begin
      if (big || up_sum[SAMPLE_BITS]) begin
        res_val = SMAX;
      end else begin
        res_val = up_sum[SAMPLE_BITS-1:0];
      end
    end else if (big || 64'(q) >= 64'(nb[4])) begin
      res_val = '0;
    end else begin
      res_val = nb[4] - q[SAMPLE_BITS-1:0] - SAMPLE_BITS'(frac);
    end
  end

  // Line store: synchronous read on request, write back during shift
  always_ff @(posedge clk) begin
    if (accept) begin
      line_q <= line_mem[in_column];
    end
    if (state == S_SHIFT) begin
      line_mem[in_column] <= {itm_tensor, itm_sample, line_q[2*SAMPLE_BITS-1:SAMPLE_BITS]};
    end
  end

  // Control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      frame_width  <= WRB'(256);
      frame_height <= HB'(256);
      step_size    <= STEP_BITS'(4096);
      in_column    <= '0;
      in_row       <= '0;
      out_column   <= '0;
      out_row      <= '0;
      pending      <= '0;
      result_valid <= 1'b0;
      tensor_hold  <= '0;
      for (int i = 0; i < NUM_TAPS; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (result_valid && result_ready && state != S_FIN) begin
        result_valid <= 1'b0;
      end
      if (cfg_accept) begin
        case (cfg_index_t'(cfg_index))
          CFG_FRAME_WIDTH: begin
            frame_width <= cfg_data[WRB-1:0];
            in_column <= '0; in_row <= '0; out_column <= '0; out_row <= '0;
            pending <= '0;
          end
          CFG_FRAME_HEIGHT: begin
            frame_height <= cfg_data[HB-1:0];
            in_column <= '0; in_row <= '0; out_column <= '0; out_row <= '0;
            pending <= '0;
          end
          CFG_STEP_SIZE: step_size <= cfg_data[STEP_BITS-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept && !(pixel.flush && pending == '0)) begin
            itm_emit   <= emit_now;
            itm_sample <= pixel.flush ? '0 : pixel.sample;
            itm_tensor <= pixel.flush ? '0 : {pixel.dyy, pixel.dxy, pixel.dxx};
            itm_last   <= pixel.flush && pending == CB'(1);
            if (pixel.flush) begin
              pending <= pending - CB'(1);
            end else if (!emit_now) begin
              pending <= pending + CB'(1);
            end
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          for (int i = 0; i < NUM_TAPS; i++) begin
            win[i] <= sh[i];
            nb[i]  <= nb_next[i];
          end
          nb_tensor   <= tensor_hold;
          tensor_hold <= line_q[DW-1:2*SAMPLE_BITS];
          nb_eof <= (32'(out_row) + 1 >= 32'(h_eff)) &&
                    (32'(out_column) + 1 >= 32'(w_eff));
          if (itm_last) begin
            in_column <= '0; in_row <= '0; out_column <= '0; out_row <= '0;
          end else begin
            if (32'(in_column) + 1 >= 32'(w_eff)) begin
              in_column <= '0;
              in_row <= (32'(in_row) + 1 >= 32'(h_eff)) ? '0 : in_row + HB'(1);
            end else begin
              in_column <= in_column + AW'(1);
            end
            if (itm_emit) begin
              if (32'(out_column) + 1 >= 32'(w_eff)) begin
                out_column <= '0;
                out_row <= (32'(out_row) + 1 >= 32'(h_eff)) ? '0 : out_row + HB'(1);
              end else begin
                out_column <= out_column + AW'(1);
              end
            end
          end
          state <= itm_emit ? S_MUL : S_IDLE;
        end
        S_MUL: begin
          p_xx  <= $signed(nb_tensor[TENSOR_BITS-1:0]) * horz_d;
          p_xy  <= $signed(nb_tensor[2*TENSOR_BITS-1:TENSOR_BITS]) * diag_d;
          p_yy  <= $signed(nb_tensor[TW-1:2*TENSOR_BITS]) * vert_d;
          state <= S_SUM;
        end
        S_SUM: begin
          neg   <= s2[SUM_BITS-1];
          mag   <= s2[SUM_BITS-1] ? MW'(-s2) : MW'(s2);
          state <= S_SCALE;
        end
        S_SCALE: begin
          prod  <= PW'(mag) * PW'(step_size);
          state <= S_FIN;
        end
        S_FIN: begin
          if (!result_valid || result_ready) begin
            result_valid        <= 1'b1;
            result.new_value    <= res_val;
            result.end_of_frame <= nb_eof;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  `TDS_ASSERT_NEXT(a_empty_flush_idle, clk, rst, accept && pixel.flush && pending == '0, state == S_IDLE, "empty flush left idle")
  `TDS_ASSERT_NOW(a_pending_bound, clk, rst, 1'b1, 32'(pending) <= 32'(w_eff) + 1, "fill count overflow")
  `TDS_ASSERT_NEXT(a_result_source, clk, rst, !result_valid && state != S_FIN, !result_valid, "result without finish stage")

endmodule
`default_nettype wire
